/* hw/rtl/icrt_pkg.sv */
// Package for the image chunk reassembly tracker.
// Holds request and result types, code enums, fixed constants and derived widths.
// No dependencies.
`timescale 1ns / 1ps

package icrt_pkg;

  // Defaults and fixed protocol constants.
  localparam int MAX_CHUNKS_DEF = 1024;
  localparam int DEFAULT_CHUNKS = 200;
  localparam int MAP_W          = 32;
  localparam int BIT_W          = $clog2(MAP_W);
  localparam int ADDR_W         = 48;
  localparam int CFG_IDX_W      = 1;

  localparam logic [7:0] TYPE_CHUNK    = 8'h49;
  localparam logic [7:0] TYPE_DONE     = 8'h44;
  localparam logic [7:0] LEN_CHUNK_MIN = 8'd7;
  localparam logic [7:0] LEN_DONE_MIN  = 8'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_ADDR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_ADDR = 1'b1;

  // Result status codes.
  typedef enum logic [2:0] {
    STS_IGNORED       = 3'd0,
    STS_STORED        = 3'd1,
    STS_DUPLICATE     = 3'd2,
    STS_OUT_OF_RANGE  = 3'd3,
    STS_COMPLETE      = 3'd4,
    STS_DROPPED       = 3'd5,
    STS_TOO_LARGE     = 3'd6,
    STS_DONE_MISMATCH = 3'd7
  } status_t;

  // Sender slot codes.
  typedef enum logic [1:0] {
    SLOT_NONE   = 2'd0,
    SLOT_FIRST  = 2'd1,
    SLOT_SECOND = 2'd2
  } slot_t;

  // Controller states.
  typedef enum logic [1:0] {
    CS_CLEAR,
    CS_IDLE,
    CS_LOOKUP,
    CS_UPDATE
  } ctl_state_t;

  // One decoded packet header.
  typedef struct packed {
    logic [7:0]        packet_length;
    logic [7:0]        type_byte;
    logic [ADDR_W-1:0] source_address;
    logic [15:0]       image_number;
    logic [15:0]       chunk_index;
    logic [15:0]       chunk_total;
    logic [31:0]       time_ms;
  } pkt_t;

  // One result.
  typedef struct packed {
    status_t     status;
    slot_t       sender_slot;
    logic [15:0] current_image;
    logic [31:0] frame_interval_ms;
    logic [10:0] chunks_counted;
  } res_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic in_ready;
    logic accept;
    logic lookup;
    logic commit;
    logic clear_step;
  } ctl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_free;
    logic need_clear;
    logic clr_last;
  } ctl_status_t;

endpackage

/* hw/rtl/icrt_channels.sv */
// Handshake channel interfaces for the image chunk reassembly tracker.
// Depends on icrt_pkg for the payload types and widths.
`timescale 1ns / 1ps

// Packet header request channel.
interface icrt_pkt_if import icrt_pkg::*; ();
  logic valid;
  logic ready;
  pkt_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Result channel.
interface icrt_res_if import icrt_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Configuration write channel.
interface icrt_cfg_if import icrt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [ADDR_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/image_chunk_reassembly_tracker.sv */
// Top level of the image chunk reassembly tracker.
// Depends on icrt_pkg, icrt_channels, icrt_ctrl, icrt_datapath and icrt_ram.
//
// Port  Direction  Moves
// ----  ---------  -----------------------------------------------
// pkt   sink       one decoded packet header per request
// res   source     one result per request (status, slot, counts)
// cfg   sink       sender address register writes, always ready
//
// A request passes through accept, bitmap row read and update, the update waiting
// for a free result register; the bitmap RAM's read-modify-write sets these steps.
// A request that clears or restarts a tracker adds a sweep over that slot's
// 2**ROW_W bitmap rows (32 rows at MAX_CHUNKS = 1024), with pkt not ready.
// After reset a clearing pass over all 2 * 2**ROW_W rows (64 by default) runs first.
// A stalled result holds the update until res is taken; the next request
// may be accepted while a result waits.
`timescale 1ns / 1ps

module image_chunk_reassembly_tracker import icrt_pkg::*; #(
  parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  icrt_pkt_if.sink      pkt,
  icrt_res_if.source    res,
  icrt_cfg_if.sink      cfg
);

  ctl_cmd_t    cmd;
  ctl_status_t sts;

  // Configuration writes are taken in any cycle.
  assign cfg.ready = 1'b1;
  assign pkt.ready = cmd.in_ready;

  icrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pkt.valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  icrt_datapath #(
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .pkt_data  (pkt.data),
    .cfg_we    (cfg.valid),
    .cfg_idx   (cfg.index),
    .cfg_data  (cfg.data),
    .res_data  (res.data),
    .res_valid (res.valid),
    .res_ready (res.ready)
  );

endmodule

/* hw/rtl/icrt_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module icrt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/icrt_ctrl.sv */
// Controller state machine for the image chunk reassembly tracker.
// Depends on icrt_pkg for the state enum and the command and status structs.
`timescale 1ns / 1ps

module icrt_ctrl import icrt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  ctl_status_t sts,
  output ctl_cmd_t    cmd
);

  ctl_state_t state, state_next;

  // State register; reset starts with the bitmap clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      CS_CLEAR: begin
        if (sts.clr_last) state_next = CS_IDLE;
      end
      CS_IDLE: begin
        if (in_valid) state_next = CS_LOOKUP;
      end
      CS_LOOKUP: begin
        state_next = CS_UPDATE;
      end
      CS_UPDATE: begin
        if (sts.out_free) state_next = sts.need_clear ? CS_CLEAR : CS_IDLE;
      end
      default: state_next = CS_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd = '0;
    unique case (state)
      CS_CLEAR:  cmd.clear_step = 1'b1;
      CS_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.accept   = in_valid;
      end
      CS_LOOKUP: cmd.lookup = 1'b1;
      CS_UPDATE: cmd.commit = sts.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

/* hw/rtl/icrt_datapath.sv */
// Datapath for the image chunk reassembly tracker: sender registers, per-slot
// trackers, the received bitmap RAM with its clearing sweep, and the result register.
// Depends on icrt_pkg and icrt_ram.
`timescale 1ns / 1ps

module icrt_datapath import icrt_pkg::*; #(
  parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctl_cmd_t             cmd,
  output ctl_status_t          sts,
  input  pkt_t                 pkt_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [ADDR_W-1:0]    cfg_data,
  output res_t                 res_data,
  output logic                 res_valid,
  input  logic                 res_ready
);

  localparam int ROWS  = (MAX_CHUNKS + MAP_W - 1) / MAP_W;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int AW    = ROW_W + 1;
  localparam int DEPTH = 2 ** AW;
  localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
  localparam logic [15:0] MAX_LIM = 16'(MAX_CHUNKS);
  localparam logic [15:0] DEF_N   = 16'(DEFAULT_CHUNKS);

  // Sender address registers.
  logic [ADDR_W-1:0] first_addr, second_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_addr  <= '0;
      second_addr <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_FIRST_ADDR:  first_addr  <= cfg_data;
        REG_SECOND_ADDR: second_addr <= cfg_data;
        default:         first_addr  <= first_addr;
      endcase
    end
  end

  // Request latch.
  pkt_t req;

  always_ff @(posedge clk) begin
    if (cmd.accept) req <= pkt_data;
  end

  // Lookup: classify the packet and match the sender.
  logic is_done_c, is_chunk_c, match1, match2, hit_c, sel_c;
  logic hit, sel, done_pkt;
  logic [ROW_W-1:0] row;

  assign is_done_c  = (req.packet_length >= LEN_DONE_MIN) && (req.type_byte == TYPE_DONE);
  assign is_chunk_c = (req.packet_length >= LEN_CHUNK_MIN) && (req.type_byte == TYPE_CHUNK);
  assign match1     = (req.source_address == first_addr);
  assign match2     = (req.source_address == second_addr);
  assign hit_c      = (match1 || match2) && (is_done_c || is_chunk_c);
  assign sel_c      = !match1;
  assign row        = req.chunk_index[BIT_W +: ROW_W];

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit      <= hit_c;
      sel      <= sel_c;
      done_pkt <= is_done_c;
    end
  end

  // Per-slot tracker state.
  logic [15:0]      tracked   [2];
  logic [15:0]      expected  [2];
  logic [CNT_W-1:0] count     [2];
  logic [31:0]      last_time [2];

  // Bitmap RAM ports.
  logic             map_we_ram, map_re;
  logic [AW-1:0]    map_waddr, map_raddr;
  logic [MAP_W-1:0] map_wdata, map_rdata;

  assign map_re    = cmd.lookup;
  assign map_raddr = {sel_c, row};

  icrt_ram #(
    .WIDTH (MAP_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .we    (map_we_ram),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (map_re),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // Update: evaluate the selected tracker against the request.
  logic [15:0]      cur, exp_cur, n16, exp_eff, fin_exp;
  logic [CNT_W-1:0] cnt_cur, cnt_eff, cnt_inc, fin_cnt;
  logic [31:0]      last_cur, interval_c;
  logic             restart, too_large, oor, dup, fin_ok;
  logic [BIT_W-1:0] bit_pos;
  logic [MAP_W-1:0] old_row, new_row;

  assign cur      = tracked[sel];
  assign exp_cur  = expected[sel];
  assign cnt_cur  = count[sel];
  assign last_cur = last_time[sel];

  assign restart   = !done_pkt && (cur != req.image_number);
  assign n16       = (req.chunk_total == 16'd0) ? DEF_N : req.chunk_total;
  assign too_large = restart && (n16 > MAX_LIM);
  assign exp_eff   = restart ? n16 : exp_cur;
  assign cnt_eff   = restart ? '0 : cnt_cur;
  assign cnt_inc   = cnt_eff + 1'b1;
  assign oor       = (req.chunk_index >= exp_eff) || (req.chunk_index >= MAX_LIM);
  assign bit_pos   = req.chunk_index[BIT_W-1:0];
  assign old_row   = restart ? '0 : map_rdata;
  assign dup       = old_row[bit_pos];
  assign new_row   = old_row | (MAP_W'(1) << bit_pos);

  // Finish check: a done packet brings its own total, a chunk the tracker's.
  assign fin_exp    = done_pkt ? req.chunk_index : exp_eff;
  assign fin_cnt    = done_pkt ? cnt_cur : cnt_inc;
  assign fin_ok     = (req.image_number != 16'd0) && (fin_exp != 16'd0) &&
                      (16'(fin_cnt) == fin_exp);
  assign interval_c = (last_cur != 32'd0) ? (req.time_ms - last_cur) : 32'd0;

  res_t             res_c;
  logic             finish, tr_clear, set_new, cnt_wr, map_set;
  logic [CNT_W-1:0] counted;

  // Decision logic for status, result fields and state updates.
  always_comb begin
    finish   = 1'b0;
    tr_clear = 1'b0;
    set_new  = 1'b0;
    cnt_wr   = 1'b0;
    map_set  = 1'b0;
    counted  = '0;
    res_c    = '0;
    res_c.status      = STS_IGNORED;
    res_c.sender_slot = SLOT_NONE;
    if (hit) begin
      res_c.sender_slot   = sel ? SLOT_SECOND : SLOT_FIRST;
      res_c.current_image = cur;
      if (done_pkt) begin
        counted = cnt_cur;
        if (cur != req.image_number) begin
          res_c.status = STS_DONE_MISMATCH;
        end else begin
          finish = 1'b1;
        end
      end else if (too_large) begin
        res_c.status = STS_TOO_LARGE;
        tr_clear     = 1'b1;
      end else begin
        set_new = restart;
        if (oor) begin
          res_c.status = STS_OUT_OF_RANGE;
          counted      = cnt_eff;
        end else if (dup) begin
          res_c.status = STS_DUPLICATE;
          counted      = cnt_eff;
        end else begin
          res_c.status = STS_STORED;
          counted      = cnt_inc;
          cnt_wr       = 1'b1;
          map_set      = 1'b1;
          finish       = (16'(cnt_inc) == exp_eff);
        end
      end
      if (finish) begin
        res_c.status            = fin_ok ? STS_COMPLETE : STS_DROPPED;
        res_c.frame_interval_ms = fin_ok ? interval_c : 32'd0;
        tr_clear                = 1'b1;
      end
    end
    res_c.chunks_counted = 11'(counted);
  end

  assign sts.need_clear = hit && (tr_clear || restart);

  // Tracker state update at commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        tracked[i]   <= '0;
        expected[i]  <= '0;
        count[i]     <= '0;
        last_time[i] <= '0;
      end
    end else if (cmd.commit && hit) begin
      if (tr_clear) begin
        tracked[sel]  <= '0;
        expected[sel] <= '0;
        count[sel]    <= '0;
        if (finish && fin_ok) last_time[sel] <= req.time_ms;
      end else begin
        if (set_new) begin
          tracked[sel]  <= req.image_number;
          expected[sel] <= n16;
        end
        if (cnt_wr) begin
          count[sel] <= cnt_inc;
        end else if (set_new) begin
          count[sel] <= '0;
        end
      end
    end
  end

  // Clearing sweep: whole RAM after reset, one slot's rows after a tracker clear or restart.
  // A row just written for a restarted image is skipped.
  logic             clr_all, clr_slot, clr_keep, skip;
  logic [ROW_W-1:0] keep_row;
  logic [AW-1:0]    clr_cnt, clr_addr;

  assign clr_addr     = clr_all ? clr_cnt : {clr_slot, clr_cnt[ROW_W-1:0]};
  assign sts.clr_last = clr_all ? (&clr_cnt) : (&clr_cnt[ROW_W-1:0]);
  assign skip         = !clr_all && clr_keep && (clr_cnt[ROW_W-1:0] == keep_row);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_all  <= 1'b1;
      clr_slot <= 1'b0;
      clr_keep <= 1'b0;
      clr_cnt  <= '0;
    end else if (cmd.commit) begin
      clr_all  <= 1'b0;
      clr_slot <= sel;
      clr_keep <= map_set && !tr_clear;
      clr_cnt  <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt <= sts.clr_last ? '0 : clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) keep_row <= row;
  end

  // Bitmap write port: sweep writes zeros, commit sets one bit.
  assign map_we_ram = (cmd.clear_step && !skip) || (cmd.commit && hit && map_set);
  assign map_waddr  = cmd.clear_step ? clr_addr : {sel, row};
  assign map_wdata  = cmd.clear_step ? '0 : new_row;

  // Result register.
  assign sts.out_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.commit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) res_data <= res_c;
  end

endmodule
